// File: hw/rtl/lavp_pkg.sv
// ----------------------------------------------------------------------------
// lavp_pkg
// Shared widths, codes and types of the look-at vertex projection core.
// ----------------------------------------------------------------------------
package lavp_pkg;

  localparam int COORD_W         = 24;
  localparam int VIEW_W          = 13;
  localparam int PIXEL_FRAC_BITS = 8;
  localparam int Q_W             = 42;
  localparam int Q_SHIFT         = 16 + PIXEL_FRAC_BITS;
  localparam int NLO_W           = Q_W - Q_SHIFT;
  localparam int UNIT_W          = 32;
  localparam int D_W             = COORD_W + 1;
  localparam int PROD_W          = D_W + UNIT_W;
  localparam int DOT_W           = PROD_W + 2;
  localparam int MAG_W           = DOT_W - 1;
  localparam int FOCAL_W         = 30;
  localparam int PIX_W           = 24;

  localparam logic [30:0] INV_2TAN25_Q30 = 31'd1151323386;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_DEPTH = 2'd1;
  localparam logic [1:0] ST_DEGEN      = 2'd2;

  localparam logic [2:0] REG_EYE_X  = 3'd0;
  localparam logic [2:0] REG_EYE_Y  = 3'd1;
  localparam logic [2:0] REG_EYE_Z  = 3'd2;
  localparam logic [2:0] REG_UP_X   = 3'd3;
  localparam logic [2:0] REG_UP_Y   = 3'd4;
  localparam logic [2:0] REG_UP_Z   = 3'd5;
  localparam logic [2:0] REG_VIEW_W = 3'd6;
  localparam logic [2:0] REG_VIEW_H = 3'd7;

  typedef struct packed {
    logic                           busy;
    logic                           degen;
    logic [2:0][UNIT_W-1:0]         fwd;
    logic [2:0][UNIT_W-1:0]         hor;
    logic [2:0][UNIT_W-1:0]         upv;
    logic [2:0][COORD_W-1:0]        eye;
    logic [FOCAL_W-1:0]             focal;
    logic [VIEW_W-1:0]              view_w;
    logic [VIEW_W-1:0]              view_h;
  } lavp_cfg_t;

  typedef struct packed {
    logic       neg_x;
    logic       neg_y;
    logic [1:0] status;
  } lavp_side_t;

endpackage

// File: hw/rtl/lavp_axis_unit.sv
// ----------------------------------------------------------------------------
// lavp_axis_unit
// Configuration registers and the sequencer that derives the camera unit axes.
// ----------------------------------------------------------------------------
module lavp_axis_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [lavp_pkg::COORD_W-1:0] cfg_wdata,
  output lavp_pkg::lavp_cfg_t          cfg_st
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_NORM  = 7'b0000100,
    S_SQR   = 7'b0001000,
    S_SQRT  = 7'b0010000,
    S_DINIT = 7'b0100000,
    S_DIV   = 7'b1000000
  } seq_state_t;

  localparam logic [1:0] VEC_FWD = 2'd0;
  localparam logic [1:0] VEC_UP  = 2'd1;
  localparam logic [1:0] VEC_HOR = 2'd2;

  logic signed [lavp_pkg::COORD_W-1:0] eye_r [3];
  logic signed [lavp_pkg::COORD_W-1:0] up_r [3];
  logic [lavp_pkg::VIEW_W-1:0]         vw_r;
  logic [lavp_pkg::VIEW_W-1:0]         vh_r;
  logic signed [47:0]                  ph_r [6];
  logic signed [48:0]                  hc_r [3];
  logic [lavp_pkg::FOCAL_W-1:0]        focal_r;
  logic [43:0]                         fprod;

  seq_state_t  state_r;
  logic [1:0]  vec_r;
  logic [1:0]  comp_r;
  logic [4:0]  cnt_r;
  logic [48:0] m_r [3];
  logic        neg_r [3];
  logic [63:0] acc_r;
  logic [63:0] root_r;
  logic [63:0] sbit_r;
  logic [31:0] dr_r;
  logic [30:0] dxl_r;
  logic [30:0] dq_r;
  logic        degen_r;
  logic signed [lavp_pkg::UNIT_W-1:0] ax_r [3][3];

  logic signed [48:0] src [3];
  logic [48:0]        srcmag [3];
  logic               hi_any;
  logic               b30_any;
  logic [61:0]        sq;
  logic [63:0]        trial;
  logic [31:0]        nroot;
  logic [61:0]        dnum;
  logic [32:0]        r2;
  logic               ge;
  logic [31:0]        uq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r[0] <= '0;
      eye_r[1] <= '0;
      eye_r[2] <= 24'sd458752;
      up_r[0]  <= '0;
      up_r[1]  <= 24'sd65536;
      up_r[2]  <= '0;
      vw_r     <= 13'd640;
      vh_r     <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lavp_pkg::REG_EYE_X:  eye_r[0] <= cfg_wdata;
        lavp_pkg::REG_EYE_Y:  eye_r[1] <= cfg_wdata;
        lavp_pkg::REG_EYE_Z:  eye_r[2] <= cfg_wdata;
        lavp_pkg::REG_UP_X:   up_r[0]  <= cfg_wdata;
        lavp_pkg::REG_UP_Y:   up_r[1]  <= cfg_wdata;
        lavp_pkg::REG_UP_Z:   up_r[2]  <= cfg_wdata;
        lavp_pkg::REG_VIEW_W: vw_r     <= cfg_wdata[lavp_pkg::VIEW_W-1:0];
        lavp_pkg::REG_VIEW_H: vh_r     <= cfg_wdata[lavp_pkg::VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  assign fprod = 44'(vh_r) * 44'(lavp_pkg::INV_2TAN25_Q30) + 44'(14'h2000);

  always_ff @(posedge clk) begin
    ph_r[0] <= up_r[2] * eye_r[1];
    ph_r[1] <= up_r[1] * eye_r[2];
    ph_r[2] <= up_r[0] * eye_r[2];
    ph_r[3] <= up_r[2] * eye_r[0];
    ph_r[4] <= up_r[1] * eye_r[0];
    ph_r[5] <= up_r[0] * eye_r[1];
    hc_r[0] <= 49'(ph_r[0]) - 49'(ph_r[1]);
    hc_r[1] <= 49'(ph_r[2]) - 49'(ph_r[3]);
    hc_r[2] <= 49'(ph_r[4]) - 49'(ph_r[5]);
    focal_r <= fprod[43:14];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (vec_r)
        VEC_FWD: src[c] = 49'(eye_r[c]);
        VEC_UP:  src[c] = 49'(up_r[c]);
        default: src[c] = hc_r[c];
      endcase
      srcmag[c] = src[c][48] ? 49'(-src[c]) : 49'(src[c]);
    end
    hi_any  = |{m_r[0][48:31], m_r[1][48:31], m_r[2][48:31]};
    b30_any = m_r[0][30] | m_r[1][30] | m_r[2][30];
    sq      = 62'(m_r[comp_r][30:0]) * 62'(m_r[comp_r][30:0]);
    trial   = root_r + sbit_r;
    nroot   = root_r[31:0];
    dnum    = (62'(m_r[comp_r][30:0]) << 30) + 62'(nroot >> 1);
    r2      = {dr_r, dxl_r[30]};
    ge      = r2 >= 33'(nroot);
    uq      = {1'b0, dq_r[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r <= S_LOAD;
      vec_r   <= VEC_FWD;
      degen_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: ;
        S_LOAD: begin
          for (int c = 0; c < 3; c++) begin
            m_r[c]   <= srcmag[c];
            neg_r[c] <= src[c][48];
          end
          if ((srcmag[0] | srcmag[1] | srcmag[2]) == '0) begin
            degen_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (hi_any) begin
            for (int c = 0; c < 3; c++) m_r[c] <= m_r[c] >> 1;
          end else if (!b30_any) begin
            for (int c = 0; c < 3; c++) m_r[c] <= m_r[c] << 1;
          end else begin
            comp_r  <= 2'd0;
            acc_r   <= '0;
            state_r <= S_SQR;
          end
        end
        S_SQR: begin
          acc_r <= acc_r + 64'(sq);
          if (comp_r == 2'd2) begin
            root_r  <= '0;
            sbit_r  <= 64'(1) << 62;
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        S_SQRT: begin
          if (acc_r >= trial) begin
            acc_r  <= acc_r - trial;
            root_r <= (root_r >> 1) + sbit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            comp_r  <= 2'd0;
            state_r <= S_DINIT;
          end
        end
        S_DINIT: begin
          dr_r    <= 32'(dnum[61:31]);
          dxl_r   <= dnum[30:0];
          dq_r    <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dr_r  <= ge ? 32'(r2 - 33'(nroot)) : r2[31:0];
          dxl_r <= dxl_r << 1;
          dq_r  <= {dq_r[29:0], ge};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd30) begin
            ax_r[vec_r][comp_r] <= neg_r[comp_r] ? -uq : uq;
            if (comp_r != 2'd2) begin
              comp_r  <= comp_r + 2'd1;
              state_r <= S_DINIT;
            end else if (vec_r == VEC_HOR) begin
              state_r <= S_IDLE;
            end else begin
              vec_r   <= vec_r + 2'd1;
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cfg_st.busy   = state_r != S_IDLE;
    cfg_st.degen  = degen_r;
    for (int c = 0; c < 3; c++) begin
      cfg_st.fwd[c] = ax_r[VEC_FWD][c];
      cfg_st.upv[c] = ax_r[VEC_UP][c];
      cfg_st.hor[c] = ax_r[VEC_HOR][c];
      cfg_st.eye[c] = eye_r[c];
    end
    cfg_st.focal  = focal_r;
    cfg_st.view_w = vw_r;
    cfg_st.view_h = vh_r;
  end

endmodule

// File: hw/rtl/lavp_front.sv
// ----------------------------------------------------------------------------
// lavp_front
// Vertex offset, projections onto the camera axes, depth and status.
// ----------------------------------------------------------------------------
module lavp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_ok,
  input  logic signed [lavp_pkg::COORD_W-1:0] vx,
  input  logic signed [lavp_pkg::COORD_W-1:0] vy,
  input  logic signed [lavp_pkg::COORD_W-1:0] vz,
  input  lavp_pkg::lavp_cfg_t                 cfg_st,
  output logic                                f_valid,
  output logic [lavp_pkg::MAG_W-1:0]          f_depth,
  output logic [lavp_pkg::MAG_W-1:0]          f_nx,
  output logic [lavp_pkg::MAG_W-1:0]          f_ny,
  output lavp_pkg::lavp_side_t                f_side
);

  logic [3:0] v_r;
  logic signed [lavp_pkg::D_W-1:0]    d_r [3];
  logic signed [lavp_pkg::PROD_W-1:0] prod_r [3][3];
  logic signed [lavp_pkg::DOT_W-1:0]  sum_r [3];
  logic [lavp_pkg::MAG_W-1:0]         depth_r, nx_r, ny_r;
  lavp_pkg::lavp_side_t               side_r;

  logic signed [lavp_pkg::COORD_W-1:0] vin [3];
  logic signed [lavp_pkg::UNIT_W-1:0]  ax [3][3];
  logic [lavp_pkg::MAG_W-1:0]          mag [3];

  always_comb begin
    vin[0] = vx;
    vin[1] = vy;
    vin[2] = vz;
    for (int c = 0; c < 3; c++) begin
      ax[0][c] = cfg_st.fwd[c];
      ax[1][c] = cfg_st.hor[c];
      ax[2][c] = cfg_st.upv[c];
    end
    for (int a = 0; a < 3; a++) begin
      mag[a] = sum_r[a][lavp_pkg::DOT_W-1] ? lavp_pkg::MAG_W'(-sum_r[a])
                                           : lavp_pkg::MAG_W'(sum_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        d_r[c] <= lavp_pkg::D_W'(vin[c]) -
                  lavp_pkg::D_W'($signed(cfg_st.eye[c]));
      end
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[a][c] <= d_r[c] * ax[a][c];
        end
        sum_r[a] <= lavp_pkg::DOT_W'(prod_r[a][0]) + lavp_pkg::DOT_W'(prod_r[a][1]) +
                    lavp_pkg::DOT_W'(prod_r[a][2]);
      end
      depth_r       <= mag[0];
      nx_r          <= mag[1];
      ny_r          <= mag[2];
      side_r.neg_x  <= sum_r[1][lavp_pkg::DOT_W-1];
      side_r.neg_y  <= sum_r[2][lavp_pkg::DOT_W-1];
      if (cfg_st.degen) begin
        side_r.status <= lavp_pkg::ST_DEGEN;
      end else if (mag[0] == '0) begin
        side_r.status <= lavp_pkg::ST_ZERO_DEPTH;
      end else begin
        side_r.status <= lavp_pkg::ST_OK;
      end
    end
  end

  assign f_valid = v_r[3];
  assign f_depth = depth_r;
  assign f_nx    = nx_r;
  assign f_ny    = ny_r;
  assign f_side  = side_r;

endmodule

// File: hw/rtl/lavp_div.sv
// ----------------------------------------------------------------------------
// lavp_div
// Pipelined restoring divider, one quotient bit per stage, for both axes.
// ----------------------------------------------------------------------------
module lavp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       d_valid,
  input  logic [lavp_pkg::MAG_W-1:0] d_depth,
  input  logic [lavp_pkg::MAG_W-1:0] d_nx,
  input  logic [lavp_pkg::MAG_W-1:0] d_ny,
  input  lavp_pkg::lavp_side_t       d_side,
  output logic                       q_valid,
  output logic [lavp_pkg::Q_W-1:0]   q_x,
  output logic [lavp_pkg::Q_W-1:0]   q_y,
  output lavp_pkg::lavp_side_t       q_side
);

  localparam int N = lavp_pkg::Q_W;

  logic [N:0]                       vld_r;
  logic [lavp_pkg::MAG_W-1:0]       den_r [N+1];
  logic [lavp_pkg::MAG_W-1:0]       rx_r [N+1];
  logic [lavp_pkg::MAG_W-1:0]       ry_r [N+1];
  logic [lavp_pkg::NLO_W-1:0]       nbx_r [N+1];
  logic [lavp_pkg::NLO_W-1:0]       nby_r [N+1];
  logic [N-1:0]                     qx_r [N+1];
  logic [N-1:0]                     qy_r [N+1];
  logic                             clx_r [N+1];
  logic                             cly_r [N+1];
  lavp_pkg::lavp_side_t             side_r [N+1];

  logic [lavp_pkg::MAG_W-1:0] r0x, r0y;

  assign r0x = d_nx >> lavp_pkg::NLO_W;
  assign r0y = d_ny >> lavp_pkg::NLO_W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N-1:0], d_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0]  <= d_depth;
      rx_r[0]   <= r0x;
      ry_r[0]   <= r0y;
      nbx_r[0]  <= d_nx[lavp_pkg::NLO_W-1:0];
      nby_r[0]  <= d_ny[lavp_pkg::NLO_W-1:0];
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      clx_r[0]  <= r0x >= d_depth;
      cly_r[0]  <= r0y >= d_depth;
      side_r[0] <= d_side;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic [lavp_pkg::MAG_W:0] r2x, r2y, dd;
    logic                     gex, gey;

    always_comb begin
      dd  = {1'b0, den_r[k-1]};
      r2x = {rx_r[k-1], nbx_r[k-1][lavp_pkg::NLO_W-1]};
      r2y = {ry_r[k-1], nby_r[k-1][lavp_pkg::NLO_W-1]};
      gex = r2x >= dd;
      gey = r2y >= dd;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[k]  <= den_r[k-1];
        rx_r[k]   <= gex ? lavp_pkg::MAG_W'(r2x - dd) : r2x[lavp_pkg::MAG_W-1:0];
        ry_r[k]   <= gey ? lavp_pkg::MAG_W'(r2y - dd) : r2y[lavp_pkg::MAG_W-1:0];
        nbx_r[k]  <= nbx_r[k-1] << 1;
        nby_r[k]  <= nby_r[k-1] << 1;
        qx_r[k]   <= {qx_r[k-1][N-2:0], gex};
        qy_r[k]   <= {qy_r[k-1][N-2:0], gey};
        clx_r[k]  <= clx_r[k-1];
        cly_r[k]  <= cly_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign q_valid = vld_r[N];
  assign q_x     = clx_r[N] ? '1 : qx_r[N];
  assign q_y     = cly_r[N] ? '1 : qy_r[N];
  assign q_side  = side_r[N];

endmodule

// File: hw/rtl/lavp_back.sv
// ----------------------------------------------------------------------------
// lavp_back
// Focal scaling, viewport centering, saturation and the output register.
// ----------------------------------------------------------------------------
module lavp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                q_valid,
  input  logic [lavp_pkg::Q_W-1:0]            q_x,
  input  logic [lavp_pkg::Q_W-1:0]            q_y,
  input  lavp_pkg::lavp_side_t                q_side,
  input  lavp_pkg::lavp_cfg_t                 cfg_st,
  output logic                                o_valid,
  output logic signed [lavp_pkg::PIX_W-1:0]   o_px,
  output logic signed [lavp_pkg::PIX_W-1:0]   o_py,
  output logic [1:0]                          o_status
);

  localparam int LO_W  = 32 + lavp_pkg::FOCAL_W;
  localparam int HI_W  = lavp_pkg::Q_W - 32 + lavp_pkg::FOCAL_W;
  localparam int OFF_W = HI_W + 1;
  localparam int PX_W  = OFF_W + 3;

  logic [2:0]                 v_r;
  logic [LO_W-1:0]            plx_r, ply_r;
  logic [HI_W-1:0]            phx_r, phy_r;
  logic [OFF_W-1:0]           offx_r, offy_r;
  lavp_pkg::lavp_side_t       s1_r, s2_r;
  logic signed [lavp_pkg::PIX_W-1:0] px_r, py_r;
  logic [1:0]                 st_r;

  logic [LO_W:0]              rlx, rly;
  logic [PX_W-1:0]            halfx, halfy;
  logic signed [PX_W-1:0]     pxs, pys;
  logic signed [lavp_pkg::PIX_W-1:0] satx, saty;

  function automatic logic signed [lavp_pkg::PIX_W-1:0] sat(input logic signed [PX_W-1:0] v);
    logic [PX_W-lavp_pkg::PIX_W:0] top;
    top = v[PX_W-1:lavp_pkg::PIX_W-1];
    if (!top[PX_W-lavp_pkg::PIX_W] && (|top)) begin
      sat = {1'b0, {(lavp_pkg::PIX_W-1){1'b1}}};
    end else if (top[PX_W-lavp_pkg::PIX_W] && !(&top)) begin
      sat = {1'b1, {(lavp_pkg::PIX_W-1){1'b0}}};
    end else begin
      sat = v[lavp_pkg::PIX_W-1:0];
    end
  endfunction

  always_comb begin
    rlx   = (LO_W + 1)'(plx_r) + ((LO_W + 1)'(1) << 31);
    rly   = (LO_W + 1)'(ply_r) + ((LO_W + 1)'(1) << 31);
    halfx = (PX_W'(cfg_st.view_w) << lavp_pkg::PIXEL_FRAC_BITS) >> 1;
    halfy = (PX_W'(cfg_st.view_h) << lavp_pkg::PIXEL_FRAC_BITS) >> 1;
    pxs   = s2_r.neg_x ? $signed(halfx + PX_W'(offx_r)) : $signed(halfx - PX_W'(offx_r));
    pys   = s2_r.neg_y ? $signed(halfy + PX_W'(offy_r)) : $signed(halfy - PX_W'(offy_r));
    satx  = sat(pxs);
    saty  = sat(pys);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plx_r  <= LO_W'(q_x[31:0]) * LO_W'(cfg_st.focal);
      ply_r  <= LO_W'(q_y[31:0]) * LO_W'(cfg_st.focal);
      phx_r  <= HI_W'(q_x[lavp_pkg::Q_W-1:32]) * HI_W'(cfg_st.focal);
      phy_r  <= HI_W'(q_y[lavp_pkg::Q_W-1:32]) * HI_W'(cfg_st.focal);
      s1_r   <= q_side;
      offx_r <= OFF_W'(phx_r) + OFF_W'(rlx >> 32);
      offy_r <= OFF_W'(phy_r) + OFF_W'(rly >> 32);
      s2_r   <= s1_r;
      if (s2_r.status != lavp_pkg::ST_OK) begin
        px_r <= '0;
        py_r <= '0;
      end else begin
        px_r <= satx;
        py_r <= saty;
      end
      st_r   <= s2_r.status;
    end
  end

  assign o_valid  = v_r[2];
  assign o_px     = px_r;
  assign o_py     = py_r;
  assign o_status = st_r;

endmodule

// File: hw/rtl/look_at_vertex_projection_core.sv
// ----------------------------------------------------------------------------
// look_at_vertex_projection_core
// Projects vertices to viewport pixels for a camera looking at the origin.
// ----------------------------------------------------------------------------
// The input channel takes one vertex item (Q8.16 x, y, z) per cycle while
// in_stall is low, and the output channel returns one item per vertex: Q16.8
// pixel x and y with a status code, in order. Both channels use valid and
// stall. The pipeline has 4 front stages, 43 divider stages (an entry stage,
// then one quotient bit per stage) and 3 back stages. Throughput is one item
// per cycle when no stall is raised.
// The user must write registers through the cfg port only while no item is in
// flight; the block itself does not enforce this. After reset and after every
// register write, a sequencer derives the three unit axes with a shared square
// root and divider; during this time in_stall is held high. When the
// receiver stalls a valid output, the whole pipeline holds and in_stall rises
// in the same cycle; no item is lost or repeated. Reset clears all valid bits
// and restores the default camera (eye 0,0,7, up 0,1,0, 640 by 480 pixels).
// ----------------------------------------------------------------------------
module look_at_vertex_projection_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lavp_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [lavp_pkg::COORD_W-1:0] in_vertex_y,
  input  logic signed [lavp_pkg::COORD_W-1:0] in_vertex_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lavp_pkg::PIX_W-1:0]   out_pixel_x,
  output logic signed [lavp_pkg::PIX_W-1:0]   out_pixel_y,
  output logic [1:0]                          out_status,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [lavp_pkg::COORD_W-1:0]        cfg_wdata
);

  lavp_pkg::lavp_cfg_t  cfg_st;
  lavp_pkg::lavp_side_t f_side, q_side;
  logic                 adv;
  logic                 f_valid, q_valid;
  logic [lavp_pkg::MAG_W-1:0] f_depth, f_nx, f_ny;
  logic [lavp_pkg::Q_W-1:0]   q_x, q_y;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = cfg_st.busy || !adv;

  lavp_axis_unit u_axis (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_st    (cfg_st)
  );

  lavp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_ok   (in_valid && !cfg_st.busy),
    .vx      (in_vertex_x),
    .vy      (in_vertex_y),
    .vz      (in_vertex_z),
    .cfg_st  (cfg_st),
    .f_valid (f_valid),
    .f_depth (f_depth),
    .f_nx    (f_nx),
    .f_ny    (f_ny),
    .f_side  (f_side)
  );

  lavp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .d_valid (f_valid),
    .d_depth (f_depth),
    .d_nx    (f_nx),
    .d_ny    (f_ny),
    .d_side  (f_side),
    .q_valid (q_valid),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_side  (q_side)
  );

  lavp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .q_valid  (q_valid),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_side   (q_side),
    .cfg_st   (cfg_st),
    .o_valid  (out_valid),
    .o_px     (out_pixel_x),
    .o_py     (out_pixel_y),
    .o_status (out_status)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == lavp_pkg::ST_OK ||
                   (out_pixel_x == '0 && out_pixel_y == '0)))
    else $error("nonzero pixel on an error item");

  a_cfg_busy: assert property (@(posedge clk) cfg_we |=> in_stall)
    else $error("input not stalled after a register write");

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
